@@ rtl/core/esfl_pkg.sv @@
// esfl_pkg: shared constants, codes and structs of the slot allocator
// no dependencies; used by esfl_store, esfl_ctrl and element_slot_free_list_core
`default_nettype none

package esfl_pkg;

    localparam int SLOTS  = 1024;
    localparam int SLOT_W = 10;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    typedef logic [SLOT_W-1:0] slot_t;

    localparam slot_t LAST_SLOT = slot_t'(SLOTS - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BAD_FREE = 2'd2
    } stat_t;

    typedef struct packed {
        logic  rd_en;
        slot_t rd_addr;
        logic  wr_en;
        slot_t wr_addr;
        slot_t wr_link;
        logic  wr_used;
    } mem_req_t;

    typedef struct packed {
        slot_t rd_link;
        logic  rd_used;
    } mem_rsp_t;

    typedef struct packed {
        logic  valid;
        slot_t granted;
        stat_t status;
        slot_t high;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/element_slot_free_list_core.sv @@
// element_slot_free_list_core: slot allocator top level, config and result registers
// depends on esfl_pkg, esfl_store and esfl_ctrl
//
//   channel   ports                                    transfer moves
//   s_        s_valid s_ready s_kind s_slot            one request item
//   m_        m_valid m_ready m_granted_slot m_status  one result item
//             m_high_mark
//   cfg_      cfg_valid cfg_ready cfg_initial_in_use   initial in-use count
//
// allocate, bad free and free below the high mark: result from the execute step
// free at the high mark: a read and a check per slot walked down in the valid-mark store
// initialize: one store write per slot
// after reset a clearing pass over every slot runs with s_ready low; cfg_ready stays high
// a waiting result holds the execute step and the final step of the next item
`default_nettype none

module element_slot_free_list_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [esfl_pkg::KIND_W-1:0]     s_kind,
    input  wire logic [esfl_pkg::SLOT_W-1:0]     s_slot,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [esfl_pkg::SLOT_W-1:0]          m_granted_slot,
    output logic [esfl_pkg::STAT_W-1:0]          m_status,
    output logic [esfl_pkg::SLOT_W-1:0]          m_high_mark,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [esfl_pkg::SLOT_W-1:0]     cfg_initial_in_use
);

    esfl_pkg::slot_t    cfg_reg;
    logic               m_valid_reg,   m_valid_next;
    esfl_pkg::slot_t    granted_reg;
    esfl_pkg::stat_t    status_reg;
    esfl_pkg::slot_t    high_reg;
    logic               out_free;
    esfl_pkg::result_t  res;
    esfl_pkg::mem_req_t req;
    esfl_pkg::mem_rsp_t rsp;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg <= cfg_initial_in_use;
        end
    end

    esfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_kind   (s_kind),
        .s_slot   (s_slot),
        .cfg_n    (cfg_reg),
        .out_free (out_free),
        .res      (res),
        .req      (req),
        .rsp      (rsp)
    );

    esfl_store u_store (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    always_comb begin
        if (res.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            granted_reg <= res.granted;
            status_reg  <= res.status;
            high_reg    <= res.high;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_granted_slot = granted_reg;
    assign m_status       = status_reg;
    assign m_high_mark    = high_reg;

endmodule

`default_nettype wire

@@ rtl/core/esfl_store.sv @@
// esfl_store: link store and valid-mark store, one write and one read port each
// depends on esfl_pkg; read data registered, held when not read
`default_nettype none

module esfl_store (
    input  wire logic              aclk,
    input  wire esfl_pkg::mem_req_t req,
    output esfl_pkg::mem_rsp_t      rsp
);

    esfl_pkg::slot_t link_mem [esfl_pkg::SLOTS];
    logic            used_mem [esfl_pkg::SLOTS];

    esfl_pkg::slot_t rd_link_reg;
    logic            rd_used_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            link_mem[req.wr_addr] <= req.wr_link;
            used_mem[req.wr_addr] <= req.wr_used;
        end
        if (req.rd_en) begin
            rd_link_reg <= link_mem[req.rd_addr];
            rd_used_reg <= used_mem[req.rd_addr];
        end
    end

    assign rsp.rd_link = rd_link_reg;
    assign rsp.rd_used = rd_used_reg;

endmodule

`default_nettype wire

@@ rtl/core/esfl_ctrl.sv @@
// esfl_ctrl: sequencer for allocate, free, high-mark walk and store rebuild
// depends on esfl_pkg; drives esfl_store through a request struct
`default_nettype none

module esfl_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [esfl_pkg::KIND_W-1:0] s_kind,
    input  wire esfl_pkg::slot_t         s_slot,
    input  wire esfl_pkg::slot_t         cfg_n,
    input  wire logic                    out_free,
    output esfl_pkg::result_t            res,
    output esfl_pkg::mem_req_t           req,
    input  wire esfl_pkg::mem_rsp_t      rsp
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_EXEC     = 5'b00010,
        ST_WALK_RD  = 5'b00100,
        ST_WALK_CHK = 5'b01000,
        ST_SWEEP    = 5'b10000
    } state_t;

    state_t          state_reg,     state_next;
    esfl_pkg::kind_t kind_reg,      kind_next;
    esfl_pkg::slot_t slot_reg,      slot_next;
    esfl_pkg::slot_t free_head_reg, free_head_next;
    esfl_pkg::slot_t top_used_reg,  top_used_next;
    esfl_pkg::slot_t walk_reg,      walk_next;
    esfl_pkg::slot_t sweep_reg,     sweep_next;
    logic            init_mode_reg, init_mode_next;

    esfl_pkg::slot_t n_cap;
    esfl_pkg::slot_t init_head;
    logic            accept;

    always_comb begin
        if ({1'b0, cfg_n} > (esfl_pkg::SLOT_W + 1)'(esfl_pkg::SLOTS - 1)) begin
            n_cap = esfl_pkg::LAST_SLOT;
        end else begin
            n_cap = cfg_n;
        end
        init_head = (n_cap == esfl_pkg::LAST_SLOT) ? '0 : n_cap + 1'b1;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        free_head_next = free_head_reg;
        top_used_next  = top_used_reg;
        walk_next      = walk_reg;
        sweep_next     = sweep_reg;
        init_mode_next = init_mode_reg;

        req         = '0;
        res         = '0;
        res.status  = esfl_pkg::STAT_OK;
        res.high    = top_used_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next   = esfl_pkg::kind_t'(s_kind);
                    slot_next   = s_slot;
                    req.rd_en   = 1'b1;
                    req.rd_addr = (s_kind == esfl_pkg::KIND_FREE) ? s_slot : free_head_reg;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    case (kind_reg)
                        esfl_pkg::KIND_ALLOC: begin
                            res.valid  = 1'b1;
                            state_next = ST_IDLE;
                            if (free_head_reg == '0) begin
                                res.status = esfl_pkg::STAT_FULL;
                            end else begin
                                req.wr_en      = 1'b1;
                                req.wr_addr    = free_head_reg;
                                req.wr_link    = '0;
                                req.wr_used    = 1'b1;
                                free_head_next = rsp.rd_link;
                                if (free_head_reg > top_used_reg) begin
                                    top_used_next = free_head_reg;
                                end
                                res.granted = free_head_reg;
                                res.high    = top_used_next;
                            end
                        end
                        esfl_pkg::KIND_FREE: begin
                            if (slot_reg == '0 || !rsp.rd_used) begin
                                res.valid  = 1'b1;
                                res.status = esfl_pkg::STAT_BAD_FREE;
                                state_next = ST_IDLE;
                            end else begin
                                req.wr_en      = 1'b1;
                                req.wr_addr    = slot_reg;
                                req.wr_link    = free_head_reg;
                                req.wr_used    = 1'b0;
                                free_head_next = slot_reg;
                                if (slot_reg == top_used_reg) begin
                                    walk_next  = slot_reg - 1'b1;
                                    state_next = ST_WALK_RD;
                                end else begin
                                    res.valid  = 1'b1;
                                    state_next = ST_IDLE;
                                end
                            end
                        end
                        esfl_pkg::KIND_INIT: begin
                            sweep_next     = '0;
                            init_mode_next = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        default: begin
                            res.valid  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = walk_reg;
                state_next  = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (rsp.rd_used || walk_reg == '0) begin
                    if (out_free) begin
                        top_used_next = walk_reg;
                        res.valid     = 1'b1;
                        res.high      = walk_reg;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    walk_next  = walk_reg - 1'b1;
                    state_next = ST_WALK_RD;
                end
            end
            ST_SWEEP: begin
                req.wr_en   = 1'b1;
                req.wr_addr = sweep_reg;
                req.wr_used = init_mode_reg && sweep_reg != '0 && sweep_reg <= n_cap;
                req.wr_link = (init_mode_reg && sweep_reg > n_cap
                               && sweep_reg != esfl_pkg::LAST_SLOT) ? sweep_reg + 1'b1 : '0;
                if (sweep_reg == esfl_pkg::LAST_SLOT) begin
                    if (!init_mode_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        free_head_next = init_head;
                        top_used_next  = n_cap;
                        init_mode_next = 1'b0;
                        res.valid      = 1'b1;
                        res.high       = n_cap;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            free_head_reg <= '0;
            top_used_reg  <= '0;
            sweep_reg     <= '0;
            init_mode_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            top_used_reg  <= top_used_next;
            sweep_reg     <= sweep_next;
            init_mode_reg <= init_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        slot_reg <= slot_next;
        walk_reg <= walk_next;
    end

    // full is only reported with an empty chain
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.status == esfl_pkg::STAT_FULL |-> free_head_reg == '0 && res.granted == '0)
        else $error("full reported with a nonempty free chain");

    // an accepted item always reaches the execute step in the following cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted item not executed");

    // a granted slot does not lie above the high mark that follows the grant
    a_grant_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.granted != '0 |=> top_used_reg >= $past(res.granted))
        else $error("high mark below granted slot");

    // store is never read and written at the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.wr_en && req.rd_en && req.wr_addr == req.rd_addr))
        else $error("read and write to the same entry");

endmodule

`default_nettype wire

@@ test/element_slot_free_list_core_checker.sv @@
`timescale 1ns / 100ps
// checker for element_slot_free_list_core: watches the config, request and result
// channels, predicts each result from its own copy of the allocator and compares
// depends on esfl_pkg
module element_slot_free_list_core_checker
    import esfl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [KIND_W-1:0] s_kind,
    input  wire slot_t             s_slot,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire slot_t             m_granted_slot,
    input  wire logic [STAT_W-1:0] m_status,
    input  wire slot_t             m_high_mark,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire slot_t             cfg_initial_in_use,
    output int                     failures,
    output int                     outstanding
);

    typedef struct packed {
        slot_t granted;
        stat_t status;
        slot_t high;
    } slot_answer_t;

    slot_t        link_mem [SLOTS];
    bit           used_mem [SLOTS];
    slot_t        free_head;
    slot_t        top_used;
    slot_t        preset_count;
    slot_answer_t answers_due [$];

    task automatic rebuild_store();
        int n;
        n = int'(preset_count);
        if (n > SLOTS - 1) begin
            n = SLOTS - 1;
        end
        for (int k = 0; k < SLOTS; k++) begin
            link_mem[k] = '0;
            used_mem[k] = (k >= 1 && k <= n);
        end
        for (int k = n + 1; k + 1 < SLOTS; k++) begin
            link_mem[k] = slot_t'(k + 1);
        end
        free_head = (n + 1 < SLOTS) ? slot_t'(n + 1) : '0;
        top_used  = slot_t'(n);
    endtask

    task automatic compute_slot_answer(input logic [KIND_W-1:0] kind, input slot_t slot,
                                       output slot_answer_t ans);
        slot_t cur;
        ans.granted = '0;
        ans.status  = STAT_OK;
        case (kind)
            KIND_ALLOC: begin
                cur = free_head;
                if (cur == '0) begin
                    ans.status = STAT_FULL;
                end else begin
                    ans.granted = cur;
                    if (cur > top_used) begin
                        top_used = cur;
                    end
                    free_head     = link_mem[cur];
                    link_mem[cur] = '0;
                    used_mem[cur] = 1'b1;
                end
            end
            KIND_FREE: begin
                if (slot == '0 || !used_mem[slot]) begin
                    ans.status = STAT_BAD_FREE;
                end else begin
                    used_mem[slot] = 1'b0;
                    link_mem[slot] = free_head;
                    free_head      = slot;
                    if (slot == top_used) begin
                        while (top_used != '0 && !used_mem[top_used]) begin
                            top_used--;
                        end
                    end
                end
            end
            KIND_INIT: begin
                rebuild_store();
            end
            default: begin
            end
        endcase
        ans.high = top_used;
    endtask

    always @(posedge aclk) begin
        slot_answer_t want;
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++) begin
                link_mem[k] = '0;
                used_mem[k] = 1'b0;
            end
            free_head    = '0;
            top_used     = '0;
            preset_count = '0;
            answers_due.delete();
            failures     = 0;
            outstanding  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: result with none pending: granted %0d status %0d high %0d",
                                 $time, m_granted_slot, m_status, m_high_mark);
                    end
                end else begin
                    want = answers_due.pop_front();
                    if (m_granted_slot !== want.granted || m_status !== want.status ||
                        m_high_mark !== want.high) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("%0t: expected granted %0d status %0d high %0d",
                                     $time, want.granted, want.status, want.high);
                            $display("%0t:      got granted %0d status %0d high %0d",
                                     $time, m_granted_slot, m_status, m_high_mark);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                preset_count = cfg_initial_in_use;
            end
            if (s_valid && s_ready) begin
                compute_slot_answer(s_kind, s_slot, want);
                answers_due.push_back(want);
            end
            outstanding = answers_due.size();
        end
    end

endmodule

@@ test/element_slot_free_list_core_tb.sv @@
`timescale 1ns / 100ps
// testbench top for element_slot_free_list_core: clock, reset, request and config
// stimulus, result back-pressure and the verdict
// depends on esfl_pkg, element_slot_free_list_core and element_slot_free_list_core_checker
module element_slot_free_list_core_tb;
    import esfl_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int REQUESTS    = 1150;
    localparam int HOLD_CYCLES = 1600;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind  = '0;
    slot_t             s_slot  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    slot_t             m_granted_slot;
    logic [STAT_W-1:0] m_status;
    slot_t             m_high_mark;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    slot_t             cfg_initial_in_use = '0;

    int    failures;
    int    outstanding;
    int    sent       = 0;
    int    burst_left = 0;
    int    cfg_now    = 0;
    slot_t granted_pool [$];
    slot_t seen_high   = '0;
    bit    hold_asked  = 1'b0;
    bit    hold_done   = 1'b0;
    int    hold_left   = 0;
    int    run_left    = 0;
    int    rx_mode;
    bit    rx_ready    = 1'b1;

    element_slot_free_list_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_slot             (s_slot),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_granted_slot     (m_granted_slot),
        .m_status           (m_status),
        .m_high_mark        (m_high_mark),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_initial_in_use (cfg_initial_in_use)
    );

    element_slot_free_list_core_checker slot_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_slot             (s_slot),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_granted_slot     (m_granted_slot),
        .m_status           (m_status),
        .m_high_mark        (m_high_mark),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_initial_in_use (cfg_initial_in_use),
        .failures           (failures),
        .outstanding        (outstanding)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver: random ready pattern plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_asked && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (run_left == 0) begin
                rx_mode = $urandom_range(0, 9);
                if (rx_mode < 3) begin
                    rx_ready = 1'b1;
                    run_left = $urandom_range(20, 80);
                end else if (rx_mode < 6) begin
                    rx_ready = 1'b1;
                    run_left = $urandom_range(1, 5);
                end else begin
                    rx_ready = 1'b0;
                    run_left = $urandom_range(1, 8);
                end
            end
            run_left--;
            m_ready <= rx_ready;
        end
    end

    // granted slots and the latest high mark steer later frees
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (m_status == STAT_OK && m_granted_slot != '0) begin
                granted_pool.push_back(m_granted_slot);
                if (granted_pool.size() > 64) begin
                    void'(granted_pool.pop_front());
                end
            end
            seen_high = m_high_mark;
        end
    end

    task automatic offer(input logic [KIND_W-1:0] kind, input slot_t slot);
        int gap;
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_slot  <= slot;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (kind == KIND_INIT) begin
            granted_pool.delete();
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_config(input slot_t count);
        cfg_valid          <= 1'b1;
        cfg_initial_in_use <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_now = int'(count);
    endtask

    initial begin
        int    r;
        int    pick;
        int    phase;
        int    drain;
        slot_t target;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // before any init the chain is empty
        offer(KIND_ALLOC, '0);
        offer(KIND_FREE, '0);
        offer(KIND_FREE, LAST_SLOT);
        offer(KIND_SPARE, 10'h155);

        quiesce();
        write_config(10'd3);
        offer(KIND_INIT, 10'h3FF);
        offer(KIND_ALLOC, '0);
        offer(KIND_ALLOC, '0);
        offer(KIND_FREE, 10'd5);
        offer(KIND_FREE, 10'd3);
        offer(KIND_FREE, 10'd4);
        offer(KIND_FREE, 10'd4);
        offer(KIND_ALLOC, '0);
        offer(KIND_ALLOC, '0);
        offer(KIND_SPARE, 10'h2AA);

        // every slot but slot 0 occupied
        quiesce();
        write_config(LAST_SLOT);
        offer(KIND_INIT, '0);
        offer(KIND_ALLOC, 10'h3FF);
        offer(KIND_FREE, LAST_SLOT);
        offer(KIND_ALLOC, '0);
        offer(KIND_ALLOC, '0);

        quiesce();
        write_config('0);
        offer(KIND_INIT, '0);
        offer(KIND_FREE, 10'd1);
        offer(KIND_ALLOC, '0);
        offer(KIND_FREE, 10'd1);

        quiesce();
        write_config(10'd1022);
        offer(KIND_INIT, '0);
        offer(KIND_ALLOC, '0);
        offer(KIND_FREE, 10'd1022);

        phase = 0;
        while (sent < REQUESTS) begin
            quiesce();
            case (phase)
                0: write_config(10'd1018);
                1: write_config('0);
                2: write_config(10'd1000);
                3: write_config(10'd1);
                4: write_config(LAST_SLOT);
                default: write_config(($urandom_range(0, 1) == 0)
                                      ? slot_t'($urandom_range(0, 1023))
                                      : slot_t'($urandom_range(980, 1023)));
            endcase
            offer(KIND_INIT, slot_t'($urandom));
            if (phase == 2) begin
                hold_asked = 1'b1;
            end
            for (int i = 0; i < 100 && sent < REQUESTS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    offer(KIND_ALLOC, slot_t'($urandom));
                end else if (r < 80) begin
                    if (granted_pool.size() != 0) begin
                        pick   = $urandom_range(0, granted_pool.size() - 1);
                        target = granted_pool[pick];
                        granted_pool.delete(pick);
                    end else begin
                        target = slot_t'($urandom_range(1, (cfg_now > 0) ? cfg_now : 1023));
                    end
                    offer(KIND_FREE, target);
                end else if (r < 88) begin
                    offer(KIND_FREE, seen_high);
                end else if (r < 94) begin
                    offer(KIND_FREE, slot_t'($urandom_range(1, (cfg_now > 0) ? cfg_now : 1)));
                end else if (r < 97) begin
                    offer(KIND_FREE, slot_t'($urandom));
                end else if (r < 98) begin
                    offer(KIND_SPARE, slot_t'($urandom));
                end else begin
                    offer(KIND_INIT, slot_t'($urandom));
                end
            end
            phase++;
        end

        s_valid <= 1'b0;
        drain = 0;
        @(posedge aclk);
        while (outstanding != 0 && drain < 50000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (40) @(posedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #1_600_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/esfl_pkg.sv
rtl/core/esfl_store.sv
rtl/core/esfl_ctrl.sv
rtl/core/element_slot_free_list_core.sv
test/element_slot_free_list_core_checker.sv
test/element_slot_free_list_core_tb.sv
